### design/sbsp_pkg.sv
// ============================================================================
// sbsp_pkg
// Shared types and codes for the shader blob stream parser: result record
// layout, record kinds, finish status codes and the parser-to-queue push.
// ============================================================================
package sbsp_pkg;

    // Record kinds
    localparam logic [1:0] KIND_NAME   = 2'd0;
    localparam logic [1:0] KIND_DESC   = 2'd1;
    localparam logic [1:0] KIND_CODE   = 2'd2;
    localparam logic [1:0] KIND_FINISH = 2'd3;

    // Finish status codes
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_BAD_MAGIC  = 2'd1;
    localparam logic [1:0] STATUS_TRUNC_TBL  = 2'd2;
    localparam logic [1:0] STATUS_TRUNC_CODE = 2'd3;

    // Result queue depth (must hold two records beyond the one on display)
    localparam int unsigned RES_FIFO_DEPTH = 4;

    typedef struct packed {
        logic [1:0]  record_kind;
        logic [7:0]  out_byte;
        logic [3:0]  uniform_type;
        logic [1:0]  shader_stage;
        logic [15:0] register_index;
        logic [15:0] register_count;
        logic [15:0] const_buffer_size;
        logic [1:0]  status;
        logic        last_of_run;
    } result_t;

    // Up to two records produced by one byte; rec_a goes out first
    typedef struct packed {
        logic [1:0] num;
        result_t     rec_a;
        result_t     rec_b;
    } push_t;

endpackage

### design/sbsp_if.sv
// ============================================================================
// sbsp_if
// Valid/ready channel interfaces: blob byte input and parsed record output.
// ============================================================================
interface sbsp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] blob_byte;
    logic       final_byte;

    modport source (output valid, output blob_byte, output final_byte, input ready);
    modport sink   (input valid, input blob_byte, input final_byte, output ready);
endinterface

interface sbsp_rec_if;
    logic        valid;
    logic        ready;
    logic [1:0]  record_kind;
    logic [7:0]  out_byte;
    logic [3:0]  uniform_type;
    logic [1:0]  shader_stage;
    logic [15:0] register_index;
    logic [15:0] register_count;
    logic [15:0] const_buffer_size;
    logic [1:0]  status;
    logic        last_of_run;

    modport source (
        output valid, input ready,
        output record_kind, output out_byte, output uniform_type, output shader_stage,
        output register_index, output register_count, output const_buffer_size,
        output status, output last_of_run
    );
    modport sink (
        input valid, output ready,
        input record_kind, input out_byte, input uniform_type, input shader_stage,
        input register_index, input register_count, input const_buffer_size,
        input status, input last_of_run
    );
endinterface

### design/shader_blob_stream_parser_core.sv
// ============================================================================
// shader_blob_stream_parser_core
// Parses a shader blob byte stream into name bytes, uniform descriptors,
// code bytes and a closing finish record.
// ============================================================================
//
//   channel   dir   handshake      payload
//   blob_in   in    valid/ready    blob_byte, final_byte
//   rec_out   out   valid/ready    record_kind .. last_of_run (one record)
//
// One byte is taken per cycle while blob_in.ready is high; its records are in
// the result queue in the next cycle. A byte gives at most two records (a
// name, descriptor or code record plus the finish record on the final byte).
// The queue drains one record per cycle while rec_out.ready is high, and
// blob_in.ready drops only while fewer than two entries are free. Reset
// clears the parse state and the queue; no clearing pass is needed. Once a
// finish record is produced all further bytes are taken and dropped.
module shader_blob_stream_parser_core
    import sbsp_pkg::*;
#(
    parameter int unsigned ResDepth = RES_FIFO_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    sbsp_byte_if.sink   blob_in,
    sbsp_rec_if.source  rec_out
);

    push_t   push;
    result_t head;
    logic    head_valid;
    logic    has_room;
    logic    accept;
    logic    pop;

    assign blob_in.ready = has_room;
    assign accept        = blob_in.valid && has_room;
    assign pop           = head_valid && rec_out.ready;

    // Parse state machine
    sbsp_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .blob_byte  (blob_in.blob_byte),
        .final_byte (blob_in.final_byte),
        .push       (push)
    );

    // Result queue
    sbsp_res_fifo #(
        .Depth (ResDepth)
    ) u_res_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .has_room   (has_room)
    );

    // Output record
    assign rec_out.valid             = head_valid;
    assign rec_out.record_kind       = head.record_kind;
    assign rec_out.out_byte          = head.out_byte;
    assign rec_out.uniform_type      = head.uniform_type;
    assign rec_out.shader_stage      = head.shader_stage;
    assign rec_out.register_index    = head.register_index;
    assign rec_out.register_count    = head.register_count;
    assign rec_out.const_buffer_size = head.const_buffer_size;
    assign rec_out.status            = head.status;
    assign rec_out.last_of_run       = head.last_of_run;

endmodule

### design/sbsp_parser.sv
// ============================================================================
// sbsp_parser
// Byte-at-a-time parse state machine. Each accepted byte updates the parse
// state and yields zero, one or two result records for the output queue.
// ============================================================================
module sbsp_parser
    import sbsp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] blob_byte,
    input  logic       final_byte,
    output push_t      push
);

    typedef enum logic [3:0] {
        PH_MAGIC    = 4'd0,
        PH_HDR      = 4'd1,
        PH_HASH     = 4'd2,
        PH_COUNT    = 4'd3,
        PH_NAMELEN  = 4'd4,
        PH_NAME     = 4'd5,
        PH_DESC     = 4'd6,
        PH_TEXSKIP  = 4'd7,
        PH_CSIZE    = 4'd8,
        PH_CODE     = 4'd9,
        PH_ATTRCNT  = 4'd10,
        PH_ATTRSKIP = 4'd11,
        PH_CBSIZE   = 4'd12
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  ver_reg, ver_next;
    logic [15:0] uleft_reg, uleft_next;
    logic [7:0]  nleft_reg, nleft_next;
    logic [7:0]  htype_reg, htype_next;
    logic [31:0] shift_reg, shift_next;
    logic [31:0] code_reg, code_next;
    logic [8:0]  skip_reg, skip_next;
    logic        done_reg, done_next;

    logic        main_v, fin_v;
    result_t     main_rec, fin_rec;
    logic [7:0]  ht;
    logic [31:0] fs;
    logic [8:0]  extra;

    // Next-state and record decode for one byte
    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        ver_next   = ver_reg;
        uleft_next = uleft_reg;
        nleft_next = nleft_reg;
        htype_next = htype_reg;
        shift_next = shift_reg;
        code_next  = code_reg;
        skip_next  = skip_reg;
        done_next  = done_reg;
        main_v     = 1'b0;
        fin_v      = 1'b0;
        main_rec   = '0;
        fin_rec    = '0;
        ht         = htype_reg;
        fs         = shift_reg;
        extra      = '0;

        if (!done_reg)
        begin
            unique case (phase_reg)
                PH_MAGIC:
                begin
                    if (blob_byte == 8'h56 || blob_byte == 8'h46 || blob_byte == 8'h43)
                    begin
                        phase_next = PH_HDR;
                        pos_next   = 3'd1;
                    end
                    else
                    begin
                        main_v               = 1'b1;
                        main_rec.record_kind = KIND_FINISH;
                        main_rec.status      = STATUS_BAD_MAGIC;
                        done_next            = 1'b1;
                    end
                end
                PH_HDR:
                begin
                    if (pos_reg == 3'd3)
                        ver_next = blob_byte;
                    if (pos_reg == 3'd7)
                    begin
                        pos_next = '0;
                        if (ver_reg >= 8'd6)
                        begin
                            skip_next  = 9'd4;
                            phase_next = PH_HASH;
                        end
                        else
                            phase_next = PH_COUNT;
                    end
                    else
                        pos_next = pos_reg + 3'd1;
                end
                PH_HASH:
                begin
                    skip_next = skip_reg - 9'd1;
                    if (skip_next == '0)
                    begin
                        phase_next = PH_COUNT;
                        pos_next   = '0;
                    end
                end
                PH_COUNT:
                begin
                    if (pos_reg == 3'd0)
                    begin
                        uleft_next = {8'd0, blob_byte};
                        pos_next   = 3'd1;
                    end
                    else
                    begin
                        uleft_next = uleft_reg | {blob_byte, 8'd0};
                        phase_next = (uleft_next != '0) ? PH_NAMELEN : PH_CSIZE;
                        pos_next   = '0;
                        shift_next = '0;
                    end
                end
                PH_NAMELEN:
                begin
                    nleft_next = blob_byte;
                    phase_next = (blob_byte != '0) ? PH_NAME : PH_DESC;
                    pos_next   = '0;
                end
                PH_NAME:
                begin
                    main_v               = 1'b1;
                    main_rec.record_kind = KIND_NAME;
                    main_rec.out_byte    = blob_byte;
                    nleft_next           = nleft_reg - 8'd1;
                    if (nleft_next == '0)
                    begin
                        phase_next = PH_DESC;
                        pos_next   = '0;
                    end
                end
                PH_DESC:
                begin
                    // type byte, one pad byte, then register and count little-endian
                    if (pos_reg == 3'd0)
                    begin
                        ht         = blob_byte;
                        htype_next = blob_byte;
                    end
                    else if (pos_reg == 3'd2)
                        fs = shift_reg | {24'd0, blob_byte};
                    else if (pos_reg == 3'd3)
                        fs = shift_reg | {16'd0, blob_byte, 8'd0};
                    else if (pos_reg == 3'd4)
                        fs = shift_reg | {8'd0, blob_byte, 16'd0};
                    else if (pos_reg == 3'd5)
                        fs = shift_reg | {blob_byte, 24'd0};

                    if (pos_reg >= 3'd5)
                    begin
                        main_v                  = 1'b1;
                        main_rec.record_kind    = KIND_DESC;
                        main_rec.uniform_type   = ht[3:0];
                        main_rec.shader_stage   = ht[5] ? 2'd2 : (ht[4] ? 2'd1 : 2'd0);
                        main_rec.register_index = fs[15:0];
                        main_rec.register_count = fs[31:16];
                        uleft_next              = uleft_reg - 16'd1;
                        extra = ((ver_reg >= 8'd8) ? 9'd2 : 9'd0)
                              + ((ver_reg >= 8'd10) ? 9'd2 : 9'd0);
                        shift_next = fs;
                        if (extra != '0)
                        begin
                            skip_next  = extra;
                            phase_next = PH_TEXSKIP;
                        end
                        else
                        begin
                            phase_next = (uleft_next != '0) ? PH_NAMELEN : PH_CSIZE;
                            pos_next   = '0;
                            shift_next = '0;
                        end
                    end
                    else
                    begin
                        shift_next = (pos_reg == 3'd1) ? 32'd0 : fs;
                        pos_next   = pos_reg + 3'd1;
                    end
                end
                PH_TEXSKIP:
                begin
                    skip_next = skip_reg - 9'd1;
                    if (skip_next == '0)
                    begin
                        phase_next = (uleft_reg != '0) ? PH_NAMELEN : PH_CSIZE;
                        pos_next   = '0;
                        shift_next = '0;
                    end
                end
                PH_CSIZE:
                begin
                    unique case (pos_reg[1:0])
                        2'd0:    fs = shift_reg | {24'd0, blob_byte};
                        2'd1:    fs = shift_reg | {16'd0, blob_byte, 8'd0};
                        2'd2:    fs = shift_reg | {8'd0, blob_byte, 16'd0};
                        default: fs = shift_reg | {blob_byte, 24'd0};
                    endcase
                    shift_next = fs;
                    if (pos_reg >= 3'd3)
                    begin
                        code_next  = fs;
                        phase_next = (fs != '0) ? PH_CODE : PH_ATTRCNT;
                        pos_next   = '0;
                    end
                    else
                        pos_next = pos_reg + 3'd1;
                end
                PH_CODE:
                begin
                    main_v               = 1'b1;
                    main_rec.record_kind = KIND_CODE;
                    main_rec.out_byte    = blob_byte;
                    code_next            = code_reg - 32'd1;
                    if (code_next == '0)
                        phase_next = PH_ATTRCNT;
                end
                PH_ATTRCNT:
                begin
                    if (blob_byte != '0)
                    begin
                        skip_next  = {blob_byte, 1'b0};
                        phase_next = PH_ATTRSKIP;
                    end
                    else
                    begin
                        phase_next = PH_CBSIZE;
                        pos_next   = '0;
                        shift_next = '0;
                    end
                end
                PH_ATTRSKIP:
                begin
                    skip_next = skip_reg - 9'd1;
                    if (skip_next == '0)
                    begin
                        phase_next = PH_CBSIZE;
                        pos_next   = '0;
                        shift_next = '0;
                    end
                end
                PH_CBSIZE:
                begin
                    if (pos_reg == 3'd0)
                    begin
                        shift_next = {24'd0, blob_byte};
                        pos_next   = 3'd1;
                    end
                    else
                    begin
                        fs                         = shift_reg | {16'd0, blob_byte, 8'd0};
                        shift_next                 = fs;
                        main_v                     = 1'b1;
                        main_rec.record_kind       = KIND_FINISH;
                        main_rec.const_buffer_size = fs[15:0];
                        main_rec.status            = STATUS_OK;
                        done_next                  = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase

            // End of blob closes the stream with a status from where it stopped
            if (!done_next && final_byte)
            begin
                fin_v               = 1'b1;
                fin_rec.record_kind = KIND_FINISH;
                done_next           = 1'b1;
                unique case (phase_next)
                    PH_TEXSKIP:
                        fin_rec.status = (uleft_next != '0) ? STATUS_TRUNC_TBL
                                                            : STATUS_TRUNC_CODE;
                    PH_CSIZE, PH_CODE:
                        fin_rec.status = STATUS_TRUNC_CODE;
                    PH_ATTRCNT, PH_ATTRSKIP, PH_CBSIZE:
                        fin_rec.status = STATUS_OK;
                    default:
                        fin_rec.status = STATUS_TRUNC_TBL;
                endcase
            end
        end
    end

    // Pack records for the queue; the last one of the byte is marked
    always_comb
    begin
        push       = '0;
        push.num   = accept ? ({1'b0, main_v} + {1'b0, fin_v}) : 2'd0;
        if (main_v)
        begin
            push.rec_a             = main_rec;
            push.rec_a.last_of_run = !fin_v;
            push.rec_b             = fin_rec;
            push.rec_b.last_of_run = 1'b1;
        end
        else
        begin
            push.rec_a             = fin_rec;
            push.rec_a.last_of_run = 1'b1;
        end
    end

    // Parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_MAGIC;
            pos_reg   <= '0;
            ver_reg   <= '0;
            uleft_reg <= '0;
            nleft_reg <= '0;
            htype_reg <= '0;
            shift_reg <= '0;
            code_reg  <= '0;
            skip_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            ver_reg   <= ver_next;
            uleft_reg <= uleft_next;
            nleft_reg <= nleft_next;
            htype_reg <= htype_next;
            shift_reg <= shift_next;
            code_reg  <= code_next;
            skip_reg  <= skip_next;
            done_reg  <= done_next;
        end
    end

    // Checks
    a_quiet_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (push.num == 2'd0))
        else $error("record produced after stream finished");

    a_pair_only_on_final: assert property (@(posedge clk) disable iff (!rst_n)
        (push.num == 2'd2) |-> (final_byte && push.rec_b.record_kind == KIND_FINISH))
        else $error("second record of a byte is not an end-of-blob finish");

    a_finish_ends_stream: assert property (@(posedge clk) disable iff (!rst_n)
        (push.num != 2'd0 && push.rec_a.record_kind == KIND_FINISH) |=> done_reg)
        else $error("finish record did not close the stream");

endmodule

### design/sbsp_res_fifo.sv
// ============================================================================
// sbsp_res_fifo
// Small result queue: takes up to two records per cycle, hands out one.
// Head entry is read straight from registers.
// ============================================================================
module sbsp_res_fifo
    import sbsp_pkg::*;
#(
    parameter int unsigned Depth = RES_FIFO_DEPTH
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    input  logic    pop,
    output result_t head,
    output logic    head_valid,
    output logic    has_room
);

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);

    result_t             mem_reg [Depth];
    logic [PtrW-1:0]     wr_ptr_reg, wr_ptr_next, wr_p1, wr_p2;
    logic [PtrW-1:0]     rd_ptr_reg, rd_ptr_next, rd_p1;
    logic [CntW-1:0]     count_reg, count_next;

    // Pointer stepping with wrap at Depth
    always_comb
    begin
        wr_p1 = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
        wr_p2 = (wr_p1 == PtrW'(Depth - 1)) ? '0 : wr_p1 + PtrW'(1);
        rd_p1 = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + PtrW'(1);

        unique case (push.num)
            2'd1:    wr_ptr_next = wr_p1;
            2'd2:    wr_ptr_next = wr_p2;
            default: wr_ptr_next = wr_ptr_reg;
        endcase
        rd_ptr_next = pop ? rd_p1 : rd_ptr_reg;
        count_next  = count_reg + CntW'(push.num) - CntW'(pop);
    end

    assign head       = mem_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign has_room   = (count_reg <= CntW'(Depth - 2));

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push.num != 2'd0)
            mem_reg[wr_ptr_reg] <= push.rec_a;
        if (push.num == 2'd2)
            mem_reg[wr_p1] <= push.rec_b;
    end

    // Queue control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(Depth))
        else $error("result queue overfilled");

    a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (push.num != 2'd0) |-> (count_reg <= CntW'(Depth - 2)))
        else $error("records pushed without room");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("pop from empty result queue");

endmodule
